@@ hw/rtl/mtrs_pkg.sv @@
// ----------------------------------------------------------------------------
// mtrs_pkg: shared types and constants for the Morton trie range step
// Operation and status codes, controller states, command and payload structs.
// ----------------------------------------------------------------------------
package mtrs_pkg;

  localparam int MaxDimsDef   = 8;
  localparam int CoordBitsDef = 32;

  localparam logic [5:0] TreeDepthRst  = 6'd32;
  localparam logic [3:0] ActiveDimsRst = 4'd8;

  typedef enum logic [2:0] {
    OP_LOAD   = 3'd0,
    OP_READ   = 3'd1,
    OP_REPR   = 3'd2,
    OP_SYMBOL = 3'd3,
    OP_NARROW = 3'd4
  } op_e;

  typedef enum logic [1:0] {
    STAT_OK      = 2'd0,
    STAT_OUTSIDE = 2'd1,
    STAT_DEEP    = 2'd2
  } status_e;

  typedef enum logic {
    REG_TREE_DEPTH  = 1'b0,
    REG_ACTIVE_DIMS = 1'b1
  } reg_e;

  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_EXEC = 2'd1,
    S_HOLD = 2'd2
  } state_e;

  typedef struct packed {
    logic capture;
    logic execute;
  } ctrl_cmd_t;

  typedef struct packed {
    logic [7:0]  child_pattern;
    logic [4:0]  level;
    logic [31:0] end_value;
    logic [31:0] start_value;
    logic [2:0]  dim_index;
    logic [2:0]  operation;
  } item_t;

  typedef struct packed {
    logic [31:0] end_out;
    logic [31:0] start_out;
    status_e     status;
    logic [7:0]  common_bits;
    logic [7:0]  differ_mask;
    logic [7:0]  morton_symbol;
  } result_t;

endpackage

@@ hw/rtl/mtrs_ctrl.sv @@
// ----------------------------------------------------------------------------
// mtrs_ctrl: transfer controller
// Accepts one item, executes it in the S_EXEC state, holds the result until taken.
// ----------------------------------------------------------------------------
module mtrs_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output mtrs_pkg::ctrl_cmd_t cmd_o
);
  import mtrs_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) state_d = S_EXEC;
      end
      S_EXEC: begin
        state_d = S_HOLD;
      end
      S_HOLD: begin
        if (out_ready_i) state_d = in_valid_i ? S_EXEC : S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o    = 1'b0;
    out_valid_o   = 1'b0;
    cmd_o.execute = 1'b0;
    unique case (state_q)
      S_IDLE: in_ready_o = 1'b1;
      S_EXEC: cmd_o.execute = 1'b1;
      S_HOLD: begin
        out_valid_o = 1'b1;
        in_ready_o  = out_ready_i;
      end
      default: ;
    endcase
    cmd_o.capture = in_valid_i & in_ready_o;
  end

endmodule

@@ hw/rtl/mtrs_dp.sv @@
// ----------------------------------------------------------------------------
// mtrs_dp: corner registers and per-dimension bit logic
// Captures an item, evaluates all dimensions side by side, registers result.
// ----------------------------------------------------------------------------
module mtrs_dp #(
  parameter int MAX_DIMS   = mtrs_pkg::MaxDimsDef,
  parameter int COORD_BITS = mtrs_pkg::CoordBitsDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  mtrs_pkg::ctrl_cmd_t cmd_i,
  input  mtrs_pkg::item_t     item_i,
  input  logic [5:0]          tree_depth_i,
  input  logic [3:0]          active_dims_i,
  output mtrs_pkg::result_t   result_o
);
  import mtrs_pkg::*;

  localparam int PosW = $clog2(COORD_BITS);

  logic [COORD_BITS-1:0] start_q [MAX_DIMS];
  logic [COORD_BITS-1:0] end_q   [MAX_DIMS];
  logic [COORD_BITS-1:0] start_d [MAX_DIMS];
  logic [COORD_BITS-1:0] end_d   [MAX_DIMS];

  item_t   item_q;
  result_t res_q, res_d;

  logic [6:0]            depth_eff;
  logic [6:0]            pos_full;
  logic [PosW-1:0]       pos;
  logic                  too_deep;
  logic [COORD_BITS-1:0] low_mask;
  logic [COORD_BITS-1:0] upto_mask;
  logic [5:0]            n_dims;
  logic [MAX_DIMS-1:0]   sb, eb, pat_ext, differ_vec, common_vec;
  logic [7:0]            symbol;
  logic [COORD_BITS-1:0] rd_start, rd_end;
  logic                  blocked;
  logic                  want, conflict;
  logic                  do_narrow, do_load;

  always_comb begin
    depth_eff = ({1'b0, tree_depth_i} > 7'(COORD_BITS)) ? 7'(COORD_BITS)
                                                        : {1'b0, tree_depth_i};
    too_deep  = {2'b00, item_q.level} >= depth_eff;
    pos_full  = depth_eff - {2'b00, item_q.level} - 7'd1;
    pos       = pos_full[PosW-1:0];
    low_mask  = (COORD_BITS'(1) << pos) - COORD_BITS'(1);
    upto_mask = {low_mask[COORD_BITS-2:0], 1'b1};
    n_dims    = (32'(active_dims_i) > MAX_DIMS) ? 6'(MAX_DIMS) : {2'b00, active_dims_i};
    pat_ext   = MAX_DIMS'(item_q.child_pattern);
  end

  always_comb begin
    rd_start = '0;
    rd_end   = '0;
    for (int j = 0; j < MAX_DIMS; j++) begin
      sb[j] = start_q[j][pos];
      eb[j] = end_q[j][pos];
      differ_vec[j] = (j < int'(n_dims)) && (sb[j] != eb[j]);
      common_vec[j] = (j < int'(n_dims)) && (sb[j] == eb[j]) && sb[j];
      if (int'(item_q.dim_index) == j) begin
        rd_start = start_q[j];
        rd_end   = end_q[j];
      end
    end
    symbol = '0;
    for (int k = 0; k < 8; k++) begin
      for (int j = 0; j < MAX_DIMS; j++) begin
        if (int'(n_dims) == j + k + 1) symbol[k] = sb[j];
      end
    end
  end

  always_comb begin
    do_narrow = cmd_i.execute && (item_q.operation == OP_NARROW) && !too_deep;
    do_load   = cmd_i.execute && (item_q.operation == OP_LOAD);
    blocked   = 1'b0;
    want      = 1'b0;
    conflict  = 1'b0;
    for (int j = 0; j < MAX_DIMS; j++) begin
      start_d[j] = start_q[j];
      end_d[j]   = end_q[j];
      want       = pat_ext[j];
      conflict   = (want && !eb[j]) || (!want && sb[j]);
      if (do_narrow && (j < int'(n_dims)) && !blocked) begin
        if (conflict) begin
          blocked = 1'b1;
        end else if (want && !sb[j]) begin
          start_d[j] = (start_q[j] & ~low_mask) | (COORD_BITS'(1) << pos);
        end else if (!want && eb[j]) begin
          end_d[j] = (end_q[j] & ~upto_mask) | low_mask;
        end
      end
      if (do_load && (int'(item_q.dim_index) == j)) begin
        start_d[j] = COORD_BITS'(item_q.start_value);
        end_d[j]   = COORD_BITS'(item_q.end_value);
      end
    end
  end

  always_comb begin
    res_d = '0;
    res_d.status = STAT_OK;
    unique case (item_q.operation)
      OP_LOAD: ;
      OP_READ: begin
        res_d.start_out = 32'(rd_start);
        res_d.end_out   = 32'(rd_end);
      end
      OP_REPR: begin
        if (too_deep) begin
          res_d.status = STAT_DEEP;
        end else begin
          res_d.differ_mask = 8'(differ_vec);
          res_d.common_bits = 8'(common_vec);
        end
      end
      OP_SYMBOL: begin
        if (too_deep) res_d.status = STAT_DEEP;
        else res_d.morton_symbol = symbol;
      end
      OP_NARROW: begin
        if (too_deep) res_d.status = STAT_DEEP;
        else if (blocked) res_d.status = STAT_OUTSIDE;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int j = 0; j < MAX_DIMS; j++) begin
        start_q[j] <= '0;
        end_q[j]   <= '0;
      end
    end else if (cmd_i.execute) begin
      for (int j = 0; j < MAX_DIMS; j++) begin
        start_q[j] <= start_d[j];
        end_q[j]   <= end_d[j];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) item_q <= item_i;
    if (cmd_i.execute) res_q <= res_d;
  end

  assign result_o = res_q;

endmodule

@@ hw/rtl/morton_trie_range_step.sv @@
// An accepted item passes through the execute and hold states before its result can transfer.
// A new item is taken in the cycle the held result transfers; no item is taken
// while one is executing, and a stalled result holds off the next item.
// Reset (rst_ni, async, active low): corners cleared to zero, tree_depth 32,
// active_dims 8, controller idle and ready.
// ----------------------------------------------------------------------------
// morton_trie_range_step: Z-order trie query box step
// Holds per-dimension start/end corners; reports agreement, Morton symbols
// and narrows the box to a child cell at a trie level.
// ----------------------------------------------------------------------------
module morton_trie_range_step #(
  parameter int MAX_DIMS   = mtrs_pkg::MaxDimsDef,
  parameter int COORD_BITS = mtrs_pkg::CoordBitsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // operation, dim_index, start_value, end_value, level, child_pattern, pad
  input  logic [87:0] s_axis_tdata,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // morton_symbol, differ_mask, common_bits, status, start_out, end_out, pad
  output logic [95:0] m_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import mtrs_pkg::*;

  logic [5:0] tree_depth_q;
  logic [3:0] active_dims_q;
  ctrl_cmd_t  cmd;
  item_t      item;
  result_t    result;
  reg_e       reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = reg_e'(paddr[2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tree_depth_q  <= TreeDepthRst;
      active_dims_q <= ActiveDimsRst;
    end else if (psel && penable && pwrite && pready) begin
      unique case (reg_sel)
        REG_TREE_DEPTH:  tree_depth_q  <= pwdata[5:0];
        REG_ACTIVE_DIMS: active_dims_q <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_TREE_DEPTH:  prdata = {26'd0, tree_depth_q};
      REG_ACTIVE_DIMS: prdata = {28'd0, active_dims_q};
      default:         prdata = '0;
    endcase
  end

  assign item = s_axis_tdata[82:0];

  mtrs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .cmd_o       (cmd)
  );

  mtrs_dp #(
    .MAX_DIMS   (MAX_DIMS),
    .COORD_BITS (COORD_BITS)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .item_i        (item),
    .tree_depth_i  (tree_depth_q),
    .active_dims_i (active_dims_q),
    .result_o      (result)
  );

  assign m_axis_tdata = {6'd0, result};

endmodule
